[src/ritoa_pkg.sv]
// Package for the radix integer-to-ASCII converter: field widths, character
// constants, the microcode word layout and the microcode program itself.
// Depends on nothing; the interfaces, the divider, the top level and the testbench import it.
package ritoa_pkg;

  localparam int unsigned InValueW = 64;
  localparam int unsigned InRadixW = 5;
  localparam int unsigned CharW    = 8;
  localparam int unsigned DigitW   = 4;

  localparam logic [CharW-1:0] ZeroChar   = 8'h30;
  localparam logic [CharW-1:0] AlphaChar  = 8'h41;
  localparam logic [InRadixW-1:0] RadixMin = 5'd2;
  localparam logic [InRadixW-1:0] RadixMax = 5'd16;

  // Microcode step addresses.
  typedef enum logic [2:0] {
    UPC_IDLE,
    UPC_CHECK,
    UPC_DINIT,
    UPC_DSTEP,
    UPC_STORE,
    UPC_RDFIRST,
    UPC_EMIT,
    UPC_BAD
  } upc_e;

  // Jump conditions; the jump target is taken when the condition holds.
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_NO_REQ,
    COND_BAD,
    COND_BITS_LEFT,
    COND_MORE,
    COND_EMIT_STAY,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    logic  in_ready;
    logic  div_load;
    logic  div_init;
    logic  div_step;
    logic  st_digit;
    logic  rd_first;
    logic  emit_digit;
    logic  emit_bad;
    cond_e cond;
    upc_e  jmp;
    upc_e  nxt;
  } ucode_t;

  // Control and status between the sequencer and the divider.
  typedef struct packed {
    logic load;
    logic init;
    logic step;
  } div_ctrl_t;

  typedef struct packed {
    logic              bits_left;
    logic              q_zero;
    logic [DigitW-1:0] rem;
  } div_status_t;

  function automatic ucode_t ucode_rom(upc_e pc);
    ucode_t w;
    w = '{default: '0, cond: COND_NEVER, jmp: UPC_IDLE, nxt: UPC_IDLE};
    case (pc)
      UPC_IDLE: begin
        w.in_ready = 1'b1;
        w.div_load = 1'b1;
        w.cond     = COND_NO_REQ;
        w.jmp      = UPC_IDLE;
        w.nxt      = UPC_CHECK;
      end
      UPC_CHECK: begin
        w.cond = COND_BAD;
        w.jmp  = UPC_BAD;
        w.nxt  = UPC_DINIT;
      end
      UPC_DINIT: begin
        w.div_init = 1'b1;
        w.nxt      = UPC_DSTEP;
      end
      UPC_DSTEP: begin
        w.div_step = 1'b1;
        w.cond     = COND_BITS_LEFT;
        w.jmp      = UPC_DSTEP;
        w.nxt      = UPC_STORE;
      end
      UPC_STORE: begin
        w.st_digit = 1'b1;
        w.cond     = COND_MORE;
        w.jmp      = UPC_DINIT;
        w.nxt      = UPC_RDFIRST;
      end
      UPC_RDFIRST: begin
        w.rd_first = 1'b1;
        w.nxt      = UPC_EMIT;
      end
      UPC_EMIT: begin
        w.emit_digit = 1'b1;
        w.cond       = COND_EMIT_STAY;
        w.jmp        = UPC_EMIT;
        w.nxt        = UPC_IDLE;
      end
      UPC_BAD: begin
        w.emit_bad = 1'b1;
        w.cond     = COND_OUT_BUSY;
        w.jmp      = UPC_BAD;
        w.nxt      = UPC_IDLE;
      end
      default: begin
        w.nxt = UPC_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic logic [CharW-1:0] glyph(logic [DigitW-1:0] d);
    logic [CharW-1:0] c;
    if (d < 4'd10) begin
      c = ZeroChar + {4'd0, d};
    end else begin
      c = AlphaChar + {4'd0, d - 4'd10};
    end
    return c;
  endfunction

endpackage

[src/ritoa_in_if.sv]
// Request channel of the converter: valid/ready plus value and radix.
// Depends on ritoa_pkg for the field widths.
interface ritoa_in_if import ritoa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [InValueW-1:0] value;
  logic [InRadixW-1:0] radix;

  modport source (output valid, value, radix, input ready);
  modport sink   (input valid, value, radix, output ready);
endinterface

[src/ritoa_out_if.sv]
// Character channel of the converter: valid/ready plus one character request.
// Depends on ritoa_pkg for the field widths.
interface ritoa_out_if import ritoa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] digit_char;
  logic             last;
  logic             bad_radix;

  modport source (output valid, digit_char, last, bad_radix, input ready);
  modport sink   (input valid, digit_char, last, bad_radix, output ready);
endinterface

[src/ritoa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module ritoa_ram #(
  parameter int unsigned Width = 4,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/ritoa_divider.sv]
// Bit-serial restoring divider: divides the running quotient by the radix,
// one quotient bit per step, leaving quotient in place and the remainder.
// Depends on ritoa_pkg for the control and status structs.
module ritoa_divider import ritoa_pkg::*; #(
  parameter int unsigned Width = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  div_ctrl_t           ctrl_i,
  input  logic [Width-1:0]    value_i,
  input  logic [InRadixW-1:0] radix_i,
  output div_status_t         status_o
);

  localparam int unsigned CntW = $clog2(Width);

  logic [Width-1:0]  quot_q, quot_d;
  logic [DigitW-1:0] rem_q, rem_d;
  logic [CntW-1:0]   bit_q, bit_d;
  logic [InRadixW-1:0] partial;
  logic                fits;

  // The remainder is always below the radix, so it fits in four bits.
  assign partial = {rem_q, quot_q[Width-1]};
  assign fits    = partial >= radix_i;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    bit_d  = bit_q;
    if (ctrl_i.load) begin
      quot_d = value_i;
    end else if (ctrl_i.init) begin
      rem_d = '0;
      bit_d = CntW'(Width - 1);
    end else if (ctrl_i.step) begin
      quot_d = {quot_q[Width-2:0], fits};
      rem_d  = fits ? DigitW'(partial - radix_i) : partial[DigitW-1:0];
      if (bit_q != '0) begin
        bit_d = bit_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quot_q <= '0;
      bit_q  <= '0;
    end else begin
      quot_q <= quot_d;
      bit_q  <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
  end

  assign status_o.bits_left = bit_q != '0;
  assign status_o.q_zero    = quot_q == '0;
  assign status_o.rem       = rem_q;

endmodule

[src/radix_integer_to_ascii.sv]
// Radix integer-to-ASCII converter, top level.
// Depends on ritoa_pkg, ritoa_in_if, ritoa_out_if, ritoa_ram and ritoa_divider.

// The block takes one request of an unsigned value (its low VALUE_WIDTH bits)
// and a radix, and returns the digits as ASCII characters, most significant
// first, one character request each, with last set on the final one. A value
// of zero gives the single character '0'. A radix outside 2 to 16 gives one
// character '0' with last and bad_radix set. At most MAX_DIGITS digits are
// produced; a value that needs more yields its MAX_DIGITS low-order digits.
// One conversion is handled at a time. A short microprogram steps a single
// bit-serial divider that divides out each digit bit by bit; a stalled output
// holds up the emission of the digits, and a bad radix goes straight to its
// error character.
// The output sits in a register, so the last character of one conversion may
// wait there while the next request is already accepted.
module radix_integer_to_ascii import ritoa_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned MAX_DIGITS  = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ritoa_in_if.sink    req_i,
  ritoa_out_if.source rsp_o
);

  localparam int unsigned AddrW = $clog2(MAX_DIGITS);
  localparam int unsigned CntW  = $clog2(MAX_DIGITS + 1);

  // Microcode sequencer state.
  upc_e   pc_q, pc_d;
  ucode_t uw;
  logic   cond_hit;

  // Datapath registers.
  logic [InRadixW-1:0] radix_q, radix_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [AddrW-1:0]    idx_q, idx_d;

  // Output register.
  logic             rsp_valid_q, rsp_valid_d;
  logic [CharW-1:0] rsp_char_q, rsp_char_d;
  logic             rsp_last_q, rsp_last_d;
  logic             rsp_bad_q, rsp_bad_d;

  logic        req_accept;
  logic        out_free;
  logic        radix_bad;
  div_ctrl_t   div_ctrl;
  div_status_t div_st;

  logic              ram_we;
  logic              ram_re;
  logic [AddrW-1:0]  ram_raddr;
  logic [DigitW-1:0] ram_rdata;

  assign uw         = ucode_rom(pc_q);
  assign req_accept = req_i.valid && uw.in_ready;
  assign req_i.ready = uw.in_ready;

  // The output slot can take a new character when it is empty or being drained.
  assign out_free  = !rsp_valid_q || rsp_o.ready;
  assign radix_bad = !(radix_q inside {[RadixMin:RadixMax]});

  // Condition evaluation and step selection.
  always_comb begin
    case (uw.cond)
      COND_NEVER:     cond_hit = 1'b0;
      COND_NO_REQ:    cond_hit = !req_i.valid;
      COND_BAD:       cond_hit = radix_bad;
      COND_BITS_LEFT: cond_hit = div_st.bits_left;
      COND_MORE:      cond_hit = !div_st.q_zero && (cnt_q != CntW'(MAX_DIGITS - 1));
      COND_EMIT_STAY: cond_hit = !out_free || (idx_q != '0);
      COND_OUT_BUSY:  cond_hit = !out_free;
      default:        cond_hit = 1'b0;
    endcase
    pc_d = cond_hit ? uw.jmp : uw.nxt;
  end

  // Datapath controls decoded from the control word.
  always_comb begin
    radix_d  = radix_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    ram_raddr = AddrW'(idx_q - AddrW'(1));

    div_ctrl.load = uw.div_load && req_accept;
    div_ctrl.init = uw.div_init;
    div_ctrl.step = uw.div_step;

    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_char_d  = rsp_char_q;
    rsp_last_d  = rsp_last_q;
    rsp_bad_d   = rsp_bad_q;

    if (req_accept) begin
      radix_d = req_i.radix;
      cnt_d   = '0;
    end

    // Digits land in the store least significant first.
    if (uw.st_digit) begin
      ram_we = 1'b1;
      cnt_d  = cnt_q + CntW'(1);
    end

    // The first read fetches the most significant digit.
    if (uw.rd_first) begin
      ram_re    = 1'b1;
      ram_raddr = AddrW'(cnt_q - CntW'(1));
      idx_d     = AddrW'(cnt_q - CntW'(1));
    end

    // Each emitted digit but the last starts the read of the next lower one.
    if (uw.emit_digit && out_free) begin
      rsp_valid_d = 1'b1;
      rsp_char_d  = glyph(ram_rdata);
      rsp_last_d  = idx_q == '0;
      rsp_bad_d   = 1'b0;
      if (idx_q != '0) begin
        ram_re = 1'b1;
        idx_d  = idx_q - AddrW'(1);
      end
    end

    if (uw.emit_bad && out_free) begin
      rsp_valid_d = 1'b1;
      rsp_char_d  = ZeroChar;
      rsp_last_d  = 1'b1;
      rsp_bad_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= UPC_IDLE;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    radix_q    <= radix_d;
    idx_q      <= idx_d;
    rsp_char_q <= rsp_char_d;
    rsp_last_q <= rsp_last_d;
    rsp_bad_q  <= rsp_bad_d;
  end

  ritoa_divider #(
    .Width (VALUE_WIDTH)
  ) u_divider (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (div_ctrl),
    .value_i  (req_i.value[VALUE_WIDTH-1:0]),
    .radix_i  (radix_q),
    .status_o (div_st)
  );

  ritoa_ram #(
    .Width (DigitW),
    .Depth (MAX_DIGITS)
  ) u_digit_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AddrW-1:0]),
    .wdata_i (div_st.rem),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.digit_char = rsp_char_q;
  assign rsp_o.last       = rsp_last_q;
  assign rsp_o.bad_radix  = rsp_bad_q;

  // The digit count never passes the store depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_DIGITS))
    else $error("digit count exceeds store depth");

  // A digit is stored only after the divider has run all its bit steps.
  a_store_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    uw.st_digit |-> !div_st.bits_left)
    else $error("digit stored before division finished");

  // A bad radix found in the check step leads straight to the error character.
  a_bad_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == UPC_CHECK && radix_bad) |=> pc_q == UPC_BAD)
    else $error("bad radix did not reach the error step");

  // An error character is always a lone '0' that closes the conversion.
  a_bad_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_bad_q) |-> (rsp_last_q && rsp_char_q == ZeroChar))
    else $error("error character malformed");

endmodule

[tb/sv/radix_integer_to_ascii_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the radix integer-to-ASCII converter. It predicts the character stream of
// every accepted request and compares it with the characters the block returns.
// Depends on ritoa_pkg and on the ritoa_in_if and ritoa_out_if channel interfaces.
module radix_integer_to_ascii_checker import ritoa_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned MAX_DIGITS  = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ritoa_in_if         req_i,
  ritoa_out_if        rsp_i,
  input  logic        drain_done_i,
  output int unsigned pending_o,
  output int unsigned fail_count_o,
  output int unsigned chars_checked_o
);

  typedef struct packed {
    logic [CharW-1:0] digit_char;
    logic             last;
    logic             bad_radix;
  } ascii_char_t;

  localparam logic [InValueW-1:0] ValueMask = {InValueW{1'b1}} >> (InValueW - VALUE_WIDTH);
  localparam logic [16*CharW-1:0] DigitGlyphs = "0123456789ABCDEF";
  localparam int unsigned PrintLimit = 30;

  ascii_char_t         expected_chars[$];
  logic [DigitW-1:0]   digit_mem [MAX_DIGITS];
  logic [6:0]          digit_total;
  logic [InValueW-1:0] quotient_left;
  int unsigned         mismatches;
  int unsigned         chars_checked;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PrintLimit) begin
      $display("[%0t] scoreboard: %s", $time, what);
    end
  endtask

  // Divides the value down by the radix, keeps the remainders least significant
  // first, and queues their characters most significant first.
  function automatic void predict_conversion(input logic [InValueW-1:0] value,
                                             input logic [InRadixW-1:0] radix);
    logic [InValueW-1:0] quot;
    logic [InValueW-1:0] base;
    logic [DigitW-1:0]   digit;
    int unsigned         count;
    ascii_char_t         ch;
    if (radix < RadixMin || radix > RadixMax) begin
      // Out-of-range radix: a single flagged '0', state left alone.
      ch.digit_char = ZeroChar;
      ch.last       = 1'b1;
      ch.bad_radix  = 1'b1;
      expected_chars.push_back(ch);
      return;
    end
    quot  = value & ValueMask;
    base  = InValueW'(radix);
    count = 0;
    if (quot == '0) begin
      digit_mem[0] = '0;
      count        = 1;
    end else begin
      while (quot != '0 && count < MAX_DIGITS) begin
        digit_mem[count] = DigitW'(quot % base);
        quot             = quot / base;
        count++;
      end
    end
    quotient_left = quot;
    digit_total   = 7'(count);
    for (int k = int'(count) - 1; k >= 0; k--) begin
      digit         = digit_mem[k];
      ch.digit_char = DigitGlyphs[(15 - int'(digit)) * CharW +: CharW];
      ch.last       = (k == 0);
      ch.bad_radix  = 1'b0;
      expected_chars.push_back(ch);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    ascii_char_t want;
    if (!rst_ni) begin
      expected_chars.delete();
      digit_total     = '0;
      quotient_left   = '0;
      mismatches      = 0;
      chars_checked   = 0;
      pending_o       <= 0;
      fail_count_o    <= 0;
      chars_checked_o <= 0;
    end else begin
      // Characters are checked before the new request is queued: a character
      // accepted on the same edge belongs to the older conversion.
      if (rsp_i.valid && rsp_i.ready) begin
        chars_checked++;
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("character %h (last %b, bad_radix %b) with none expected",
                                    rsp_i.digit_char, rsp_i.last, rsp_i.bad_radix));
        end else begin
          want = expected_chars.pop_front();
          if (rsp_i.digit_char !== want.digit_char) begin
            report_mismatch($sformatf("digit_char %h, expected %h",
                                      rsp_i.digit_char, want.digit_char));
          end
          if (rsp_i.last !== want.last) begin
            report_mismatch($sformatf("last %b, expected %b on character %h",
                                      rsp_i.last, want.last, want.digit_char));
          end
          if (rsp_i.bad_radix !== want.bad_radix) begin
            report_mismatch($sformatf("bad_radix %b, expected %b on character %h",
                                      rsp_i.bad_radix, want.bad_radix, want.digit_char));
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        predict_conversion(req_i.value, req_i.radix);
      end
      if (drain_done_i && expected_chars.size() != 0) begin
        report_mismatch($sformatf("%0d expected characters never arrived",
                                  expected_chars.size()));
        expected_chars.delete();
      end
      pending_o       <= expected_chars.size();
      fail_count_o    <= mismatches;
      chars_checked_o <= chars_checked;
    end
  end

endmodule

[tb/sv/radix_integer_to_ascii_tb.sv]
`timescale 1ns / 1ps
// Top of the radix integer-to-ASCII converter testbench: clock, reset, request
// stimulus, character back-pressure and the final verdict.
// Depends on ritoa_pkg, the channel interfaces, the block and the scoreboard module.
module radix_integer_to_ascii_tb;
  import ritoa_pkg::*;

  localparam int unsigned ValueWidth     = 64;
  localparam int unsigned MaxDigits      = 64;
  localparam int unsigned RandomRequests = 286;
  // At most two conversions can be in flight, so this limit bounds the final drain.
  localparam int unsigned DrainLimit     = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        drain_done;
  // While set, neither side inserts idle cycles, so long stretches run at full rate.
  logic        quiet_phase;
  int unsigned pending;
  int unsigned fail_count;
  int unsigned chars_checked;
  int unsigned requests_sent = 0;
  int unsigned bad_radix_sent = 0;
  int unsigned rsp_hold;

  ritoa_in_if  req_if ();
  ritoa_out_if rsp_if ();

  radix_integer_to_ascii #(
    .VALUE_WIDTH(ValueWidth),
    .MAX_DIGITS (MaxDigits)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  radix_integer_to_ascii_checker #(
    .VALUE_WIDTH(ValueWidth),
    .MAX_DIGITS (MaxDigits)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_if),
    .rsp_i          (rsp_if),
    .drain_done_i   (drain_done),
    .pending_o      (pending),
    .fail_count_o   (fail_count),
    .chars_checked_o(chars_checked)
  );

  always #5 clk_i = ~clk_i;

  // Character sink. After every accepted character outside the quiet phase it
  // draws a random stall, so ready drops at every point of a conversion's output,
  // including while the last character of one conversion waits for the next.
  always @(posedge clk_i or negedge rst_ni) begin : rsp_sink
    int unsigned draw;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      rsp_hold     <= 0;
    end else if (rsp_if.valid && rsp_if.ready) begin
      if (quiet_phase) begin
        rsp_if.ready <= 1'b1;
        rsp_hold     <= 0;
      end else begin
        draw = $urandom_range(0, 3);
        rsp_if.ready <= (draw == 0);
        rsp_hold     <= (draw != 0) ? draw - 1 : 0;
      end
    end else if (rsp_hold != 0) begin
      rsp_if.ready <= 1'b0;
      rsp_hold     <= rsp_hold - 1;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // Presents one conversion request after a random idle gap and holds it until
  // the block takes it. With no gap, valid stays high from the previous request.
  task automatic send_request(input logic [InValueW-1:0] value,
                              input logic [InRadixW-1:0] radix);
    int unsigned gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.value <= value;
    req_if.radix <= radix;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
    requests_sent++;
    if (radix < RadixMin || radix > RadixMax) begin
      bad_radix_sent++;
    end
  endtask

  initial begin : stimulus
    logic [InValueW-1:0] value;
    logic [InRadixW-1:0] radix;
    int unsigned         pick;
    int unsigned         width;
    // The reset edge at time zero also clears the sink and the scoreboard.
    rst_ni       <= 1'b0;
    drain_done   <= 1'b0;
    quiet_phase  <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.value <= '0;
    req_if.radix <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. A zero value must still give one '0'. All ones in radix 2
    // and a top-bit-only value both fill every digit slot; the decimal maximum is
    // the longest decimal string; the radix-16 pattern walks every glyph.
    send_request('0, 5'd10);
    send_request('1, 5'd2);
    send_request(64'h8000_0000_0000_0000, 5'd2);
    send_request('1, 5'd10);
    send_request(64'hFEDC_BA98_7654_3210, 5'd16);
    // Every legal radix once, with a full-width random value.
    for (int r = 2; r <= 16; r++) begin
      send_request({$urandom, $urandom}, InRadixW'(r));
    end
    // Out-of-range radices at both ends of the field, each giving a flagged '0'.
    send_request('0, 5'd0);
    send_request({$urandom, $urandom}, 5'd1);
    send_request({$urandom, $urandom}, 5'd17);
    send_request('1, 5'd31);

    // Random part. Most requests are legal conversions, half of them short
    // values so the run stays quick; the rest are full-width values, the extremes
    // and a share of out-of-range radices.
    for (int n = 0; n < RandomRequests; n++) begin
      quiet_phase <= (n % 60) >= 45;
      if (n % 70 == 35) begin
        // Let the block run dry before going on.
        req_if.valid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        radix = InRadixW'($urandom_range(0, 16));
        if (radix >= RadixMin) begin
          radix = radix + 5'd15;
        end
        value = {$urandom, $urandom};
      end else begin
        radix = InRadixW'($urandom_range(2, 16));
        pick  = $urandom_range(0, 99);
        width = $urandom_range(1, 16);
        if (pick < 50) begin
          value = {$urandom, $urandom} >> (InValueW - width);
        end else if (pick < 88) begin
          value = {$urandom, $urandom};
        end else if (pick < 94) begin
          value = '1;
        end else begin
          value = '0;
        end
      end
      send_request(value, radix);
    end

    // Drain: wait for every predicted character, then give the block time to
    // show any stray output before the scoreboard looks for leftovers.
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    for (int c = 0; c < DrainLimit && pending != 0; c++) begin
      @(posedge clk_i);
    end
    repeat (100) @(posedge clk_i);
    drain_done <= 1'b1;
    repeat (3) @(posedge clk_i);

    $display("Converted %0d requests (%0d with an out-of-range radix), %0d characters checked.",
             requests_sent, bad_radix_sent, chars_checked);
    $display("Radices 2 to 16, zero and all-ones values and 64-digit results were all exercised.");
    if (fail_count == 0) begin
      $display("radix_integer_to_ascii regression: pass");
    end else begin
      $display("radix_integer_to_ascii regression: fail");
    end
    $finish;
  end

  // Watchdog. The slowest correct run, with every request a 64-digit conversion
  // and every character stalled, ends before this timeout.
  initial begin
    #50_000_000;
    $display("Run timed out with %0d characters still expected.", pending);
    $display("radix_integer_to_ascii regression: fail");
    $finish;
  end

endmodule
